// ===== rtl/dpru_pkg.sv =====
// Shared types and constants for the DIB pixel row unpacker.
package dpru_pkg;

    // Default size limits of the image
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    // Reset values of the registers
    localparam logic [2:0] PIXEL_FORMAT_RST = 3'd4;
    localparam logic [8:0] IMAGE_WIDTH_RST  = 9'd16;
    localparam logic [8:0] IMAGE_HEIGHT_RST = 9'd16;

    // Pixel format codes as written to the format register
    localparam logic [2:0] FMT_1BPP  = 3'd0;
    localparam logic [2:0] FMT_4BPP  = 3'd1;
    localparam logic [2:0] FMT_8BPP  = 3'd2;
    localparam logic [2:0] FMT_24BPP = 3'd3;

    typedef enum logic [2:0] {
        MODE_1BPP,
        MODE_4BPP,
        MODE_8BPP,
        MODE_24BPP,
        MODE_32BPP
    } mode_t;

    // One input byte's worth of work for the back end
    typedef struct packed {
        mode_t       mode;
        logic [31:0] value;      // raw byte in low bits, or finished ARGB word
        logic [7:0]  column;     // column of the first pixel
        logic [7:0]  row;        // flipped image row
        logic [3:0]  count;      // pixels to emit, 1 to 8
        logic        end_image;  // last pixel of this byte ends the image
    } desc_t;

endpackage

// ===== rtl/dpru_front.sv =====
// Front end: tracks the position in the stored image and classifies each byte.
module dpru_front
    import dpru_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        restart,
    input  logic [2:0]  pixel_format,
    input  logic [8:0]  image_width,
    input  logic [8:0]  image_height,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        queue_full,
    output logic        push,
    output desc_t       push_desc
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int BW = CW + 2;
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [BW-1:0] byte_in_row_reg, byte_in_row_next;
    logic [HW-1:0] stored_row_reg, stored_row_next;
    logic [CW-1:0] next_column_reg, next_column_next;
    logic [1:0]    byte_in_pixel_reg, byte_in_pixel_next;
    logic [23:0]   gathered_reg, gathered_next;

    mode_t         mode;
    logic [CW-1:0] w;
    logic [HW-1:0] h;
    logic [CW+4:0] row_bits;
    logic [CW+5:0] row_bits_up;
    logic [BW-1:0] stride;
    logic [CW-1:0] remaining;
    logic [3:0]    per_byte;
    logic [3:0]    count;
    logic [31:0]   value;
    logic          col_ok;
    logic          accept;
    logic [31:0]   row_full;
    logic [31:0]   col_full;

    // Decode the format, unknown codes act as 32 bit
    always_comb
    begin
        unique case (pixel_format)
            FMT_1BPP:  mode = MODE_1BPP;
            FMT_4BPP:  mode = MODE_4BPP;
            FMT_8BPP:  mode = MODE_8BPP;
            FMT_24BPP: mode = MODE_24BPP;
            default:   mode = MODE_32BPP;
        endcase
    end

    // Clamp the dimensions to the supported range
    always_comb
    begin
        if (image_width == '0)
            w = CW'(1);
        else if (int'(image_width) > MAX_WIDTH)
            w = CW'(MAX_WIDTH);
        else
            w = CW'(image_width);

        if (image_height == '0)
            h = HW'(1);
        else if (int'(image_height) > MAX_HEIGHT)
            h = HW'(MAX_HEIGHT);
        else
            h = HW'(image_height);
    end

    // Row stride in bytes, rounded up to four-byte words
    always_comb
    begin
        case (mode)
            MODE_1BPP:  row_bits = (CW+5)'(w);
            MODE_4BPP:  row_bits = (CW+5)'(w) << 2;
            MODE_8BPP:  row_bits = (CW+5)'(w) << 3;
            MODE_24BPP: row_bits = ((CW+5)'(w) << 4) + ((CW+5)'(w) << 3);
            default:    row_bits = (CW+5)'(w) << 5;
        endcase
        row_bits_up = (CW+6)'(row_bits) + (CW+6)'(31);
        stride      = {row_bits_up[CW+4:5], 2'b00};
    end

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign col_ok   = next_column_reg < w;
    assign remaining = w - next_column_reg;

    // Classify the byte: pixel count, value and gather state
    always_comb
    begin
        gathered_next      = gathered_reg;
        byte_in_pixel_next = byte_in_pixel_reg;
        value              = {24'd0, s_tdata};
        count              = 4'd0;

        case (mode)
            MODE_1BPP: per_byte = 4'd8;
            MODE_4BPP: per_byte = 4'd2;
            default:   per_byte = 4'd1;
        endcase

        if (mode == MODE_1BPP || mode == MODE_4BPP || mode == MODE_8BPP)
        begin
            if (col_ok)
            begin
                if (32'(remaining) < 32'(per_byte))
                    count = 4'(remaining);
                else
                    count = per_byte;
            end
        end
        else if (col_ok)
        begin
            if ((mode == MODE_24BPP && byte_in_pixel_reg >= 2'd2) ||
                (mode == MODE_32BPP && byte_in_pixel_reg == 2'd3))
            begin
                count = 4'd1;
                if (mode == MODE_24BPP)
                    value = {8'hff, s_tdata, gathered_reg[15:0]};
                else
                    value = {s_tdata, gathered_reg};
                gathered_next      = '0;
                byte_in_pixel_next = 2'd0;
            end
            else
            begin
                case (byte_in_pixel_reg)
                    2'd0:    gathered_next = {gathered_reg[23:8], s_tdata};
                    2'd1:    gathered_next = {gathered_reg[23:16], s_tdata, gathered_reg[7:0]};
                    default: gathered_next = {s_tdata, gathered_reg[15:0]};
                endcase
                byte_in_pixel_next = byte_in_pixel_reg + 2'd1;
            end
        end
    end

    // Build the queue entry
    assign row_full = 32'(h) - 32'd1 - 32'(stored_row_reg);
    assign col_full = 32'(next_column_reg);
    assign push     = accept && (count != 4'd0);

    always_comb
    begin
        push_desc.mode      = mode;
        push_desc.value     = value;
        push_desc.column    = col_full[7:0];
        push_desc.row       = row_full[7:0];
        push_desc.count     = count;
        push_desc.end_image = (stored_row_reg == h - HW'(1)) &&
                              ((CW+1)'(next_column_reg) + (CW+1)'(count) == (CW+1)'(w));
    end

    // Advance the position, wrap at the end of each stored row
    always_comb
    begin
        byte_in_row_next = byte_in_row_reg;
        stored_row_next  = stored_row_reg;
        next_column_next = next_column_reg + CW'(count);
        if ((BW+1)'(byte_in_row_reg) + (BW+1)'(1) >= (BW+1)'(stride))
        begin
            byte_in_row_next = '0;
            next_column_next = '0;
            if (stored_row_reg >= h - HW'(1))
                stored_row_next = '0;
            else
                stored_row_next = stored_row_reg + HW'(1);
        end
        else
        begin
            byte_in_row_next = byte_in_row_reg + BW'(1);
        end
    end

    // Hold the position state, clear it on restart
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_in_row_reg   <= '0;
            stored_row_reg    <= '0;
            next_column_reg   <= '0;
            byte_in_pixel_reg <= '0;
            gathered_reg      <= '0;
        end
        else if (restart)
        begin
            byte_in_row_reg   <= '0;
            stored_row_reg    <= '0;
            next_column_reg   <= '0;
            byte_in_pixel_reg <= '0;
            gathered_reg      <= '0;
        end
        else if (accept)
        begin
            byte_in_row_reg <= byte_in_row_next;
            stored_row_reg  <= stored_row_next;
            next_column_reg <= next_column_next;
            if (byte_in_row_next == '0)
            begin
                byte_in_pixel_reg <= '0;
                gathered_reg      <= '0;
            end
            else
            begin
                byte_in_pixel_reg <= byte_in_pixel_next;
                gathered_reg      <= gathered_next;
            end
        end
    end

endmodule

// ===== rtl/dpru_queue.sv =====
// Short queue of byte descriptors between front and back end.
module dpru_queue
    import dpru_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output desc_t head_desc
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    desc_t           entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     fill_reg;

    assign full       = fill_reg == (PW+1)'(QUEUE_DEPTH);
    assign head_valid = fill_reg != '0;
    assign head_desc  = entry_reg[rd_ptr_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + PW'(1);
            if (push && !pop)
                fill_reg <= fill_reg + (PW+1)'(1);
            else if (pop && !push)
                fill_reg <= fill_reg - (PW+1)'(1);
        end
    end

endmodule

// ===== rtl/dpru_back.sv =====
// Back end: expands each descriptor into pixels through the output register.
module dpru_back
    import dpru_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  desc_t       head_desc,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tuser
);

    logic [2:0]  pix_reg;
    logic        valid_reg;
    logic [31:0] value_reg;
    logic [7:0]  column_reg;
    logic [7:0]  row_reg;
    logic        last_byte_reg;
    logic        last_image_reg;

    logic        advance;
    logic        final_pix;
    logic [31:0] pix_value;
    logic [2:0]  bit_sel;

    assign advance   = !valid_reg || m_tready;
    assign final_pix = 4'(pix_reg) + 4'd1 == head_desc.count;
    assign pop       = advance && head_valid && final_pix;
    assign bit_sel   = 3'd7 - pix_reg;

    // Pick the pixel out of the byte, most significant bits first
    always_comb
    begin
        case (head_desc.mode)
            MODE_1BPP: pix_value = {31'd0, head_desc.value[bit_sel]};
            MODE_4BPP: pix_value = (pix_reg == 3'd0) ? {28'd0, head_desc.value[7:4]}
                                                    : {28'd0, head_desc.value[3:0]};
            MODE_8BPP: pix_value = {24'd0, head_desc.value[7:0]};
            default:   pix_value = head_desc.value;
        endcase
    end

    // Step through the pixels of the head entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= head_valid;
            if (head_valid)
                pix_reg <= final_pix ? 3'd0 : pix_reg + 3'd1;
        end
    end

    // Load the output payload
    always_ff @(posedge clk)
    begin
        if (advance && head_valid)
        begin
            value_reg      <= pix_value;
            column_reg     <= head_desc.column + 8'(pix_reg);
            row_reg        <= head_desc.row;
            last_byte_reg  <= final_pix;
            last_image_reg <= final_pix && head_desc.end_image;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {row_reg, column_reg, value_reg};
    assign m_tlast  = last_byte_reg;
    assign m_tuser  = last_image_reg;

endmodule

// ===== rtl/dib_pixel_row_unpacker_unit.sv =====
// Top level of the DIB pixel row unpacker with its configuration registers.
// Takes the pixel-data bytes of a bottom-up bitmap, one byte per transaction, and emits one
// transaction per pixel: a palette index for 1, 4 and 8 bit formats or an ARGB word for 24
// and 32 bit formats, with column, flipped row, an end-of-byte mark (tlast) and an
// end-of-image flag (tuser). A byte is accepted every cycle while the two-entry queue between
// the front end and the back end has room; pixels leave at one per cycle while the receiver is
// ready, so in 8, 24 and 32 bit formats the block sustains one byte per cycle; in 4 and 1 bit
// formats a byte gives up to two or eight pixels. A pixel passes through a queue entry and
// the output register after the byte that completes it. Padding bytes and bits past the row
// width give no transaction. Any write to a known register restarts the image.
module dib_pixel_row_unpacker_unit
    import dpru_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Byte input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    // Pixel output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] pixel_value, [39:32] column, [47:40] row
    output logic        m_tlast,   // last_of_byte
    output logic        m_tuser    // [0] last_pixel
);

    logic [2:0] pixel_format_reg;
    logic [8:0] image_width_reg;
    logic [8:0] image_height_reg;
    logic       cfg_write;
    logic       restart;
    logic       queue_full;
    logic       push;
    desc_t      push_desc;
    logic       pop;
    logic       head_valid;
    desc_t      head_desc;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Write the registers; a write to a known register restarts the image
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg <= PIXEL_FORMAT_RST;
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_PIXEL_FORMAT: pixel_format_reg <= pwdata[2:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[8:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[8:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        restart = 1'b0;
        prdata  = '0;
        unique case (paddr[3:2])
            REG_PIXEL_FORMAT:
            begin
                restart = cfg_write;
                prdata  = {29'd0, pixel_format_reg};
            end
            REG_IMAGE_WIDTH:
            begin
                restart = cfg_write;
                prdata  = {23'd0, image_width_reg};
            end
            REG_IMAGE_HEIGHT:
            begin
                restart = cfg_write;
                prdata  = {23'd0, image_height_reg};
            end
            default: ;
        endcase
    end

    dpru_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (restart),
        .pixel_format (pixel_format_reg),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .queue_full   (queue_full),
        .push         (push),
        .push_desc    (push_desc)
    );

    dpru_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    dpru_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

// ===== rtl/dpru_checker.sv =====
// Port-level checks on the pixel output of the unpacker, bound to the top level.
module dpru_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // Hold a stalled transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output transaction changed");

    // The final pixel of the image also ends its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("last pixel of image without end-of-byte mark");

    // The final pixel of the image lies on the top row
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[47:40] == 8'd0)
        else $error("last pixel of image not on row zero");

endmodule

bind dib_pixel_row_unpacker_unit dpru_checker u_dpru_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== tb/tb_dib_pixel_row_unpacker_unit.sv =====
// Self-checking bench for the DIB pixel row unpacker: byte stream in, checked pixels out.
module tb_dib_pixel_row_unpacker_unit;
    import dpru_pkg::*;

    // Codes beyond the named formats; the block treats them as 32 bit BGRA
    localparam logic [2:0] FMT_32BPP     = 3'd4;
    localparam logic [2:0] FMT_UNUSED_LO = 3'd5;
    localparam logic [2:0] FMT_UNUSED_HI = 3'd7;
    // Register index past the end of the register map
    localparam logic [1:0] REG_NONE      = 2'd3;

    localparam int SETTLE_CYCLES  = 16;
    localparam int STALL_LIMIT    = 2000;
    localparam int RANDOM_BYTES   = 95;
    localparam int MAX_PHASE_LEN  = 40;
    localparam int SHOWN_MISMATCH = 10;

    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  column;
        logic [7:0]  row;
        logic        last_of_byte;
        logic        last_pixel;
    } pixel_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] data_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // [31:0] pixel_value, [39:32] column, [47:40] row
    logic        m_tlast;         // last_of_byte
    logic        m_tuser;         // [0] last_pixel

    dib_pixel_row_unpacker_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // Register copies and unpacking state of the predictor
    logic [2:0]  fmt_reg    = PIXEL_FORMAT_RST;
    logic [8:0]  width_reg  = IMAGE_WIDTH_RST;
    logic [8:0]  height_reg = IMAGE_HEIGHT_RST;
    int          byte_pos   = 0;
    int          cur_row    = 0;
    int          cur_col    = 0;
    int          pix_byte   = 0;
    logic [23:0] gather     = '0;

    logic [7:0] pending_bytes[$];
    pixel_t     expected_pixels[$];
    logic       no_gaps      = 1'b0;
    int         bytes_sent   = 0;
    int         pixels_seen  = 0;
    int         mismatches   = 0;
    int         stall_count  = 0;
    int         settings_run = 1;

    function automatic int eff_dim(input logic [8:0] v, input int limit);
        if (v == 0)
            return 1;
        if (int'(v) > limit)
            return limit;
        return int'(v);
    endfunction

    function automatic int bits_per_pixel(input logic [2:0] f);
        case (f)
            FMT_1BPP:  return 1;
            FMT_4BPP:  return 4;
            FMT_8BPP:  return 8;
            FMT_24BPP: return 24;
            default:   return 32;
        endcase
    endfunction

    // Unpack one accepted byte into the pixels it completes and advance the row position
    function automatic void predict_pixels(input logic [7:0] b);
        int w;
        int h;
        int bpp;
        int stride;
        int per;
        int done_at;
        logic [7:0] row_out;
        pixel_t px;
        pixel_t produced[$];
        w       = eff_dim(width_reg, DEF_MAX_WIDTH);
        h       = eff_dim(height_reg, DEF_MAX_HEIGHT);
        bpp     = bits_per_pixel(fmt_reg);
        stride  = ((w * bpp + 31) / 32) * 4;
        row_out = 8'(h - 1 - cur_row);
        px      = '0;
        if (bpp <= 8) begin
            per = 8 / bpp;
            for (int k = 0; k < per && cur_col < w; k++) begin
                px.value      = 32'((int'(b) >> (8 - bpp * (k + 1))) & ((1 << bpp) - 1));
                px.column     = 8'(cur_col);
                px.row        = row_out;
                px.last_pixel = (cur_col == w - 1) && (cur_row == h - 1);
                produced.push_back(px);
                cur_col++;
            end
        end else if (cur_col < w) begin
            done_at = (bpp == 24) ? 2 : 3;
            if (pix_byte >= done_at) begin
                px.value      = (bpp == 24) ? {8'hff, b, gather[15:0]} : {b, gather};
                px.column     = 8'(cur_col);
                px.row        = row_out;
                px.last_pixel = (cur_col == w - 1) && (cur_row == h - 1);
                produced.push_back(px);
                cur_col++;
                pix_byte = 0;
                gather   = '0;
            end else begin
                gather   = gather | (24'(b) << (8 * pix_byte));
                pix_byte = pix_byte + 1;
            end
        end
        if (produced.size() > 0)
            produced[produced.size() - 1].last_of_byte = 1'b1;
        foreach (produced[i])
            expected_pixels.push_back(produced[i]);
        // Wrap to the next stored row after the last byte of the stored row
        if (byte_pos + 1 >= stride) begin
            byte_pos = 0;
            cur_col  = 0;
            pix_byte = 0;
            gather   = '0;
            cur_row++;
            if (cur_row >= h)
                cur_row = 0;
        end else begin
            byte_pos++;
        end
    endfunction

    // Byte driver: hold on backpressure, otherwise take the next byte or idle
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_pixels(s_tdata);
                bytes_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_bytes.size() > 0 && (no_gaps || $urandom_range(99) >= 36)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_bytes.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Pixel receiver stalls at random
    always @(posedge clk)
        m_tready <= rst_n && (no_gaps || $urandom_range(99) >= 36);

    // Pixel monitor: compare each transaction with the oldest expected pixel
    always @(posedge clk) begin
        pixel_t got;
        pixel_t exp_px;
        if (rst_n && m_tvalid && m_tready) begin
            got = {m_tdata[31:0], m_tdata[39:32], m_tdata[47:40], m_tlast, m_tuser};
            pixels_seen++;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCH)
                    $display("ERROR: pixel with none expected: value %08h col %0d row %0d",
                             got.value, got.column, got.row);
            end else begin
                exp_px = expected_pixels.pop_front();
                if (got !== exp_px) begin
                    mismatches++;
                    if (mismatches <= SHOWN_MISMATCH)
                        $display({"ERROR: pixel mismatch exp val %08h col %0d row %0d ",
                                  "lob %0b lp %0b, got val %08h col %0d row %0d lob %0b lp %0b"},
                                 exp_px.value, exp_px.column, exp_px.row,
                                 exp_px.last_of_byte, exp_px.last_pixel,
                                 got.value, got.column, got.row,
                                 got.last_of_byte, got.last_pixel);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !rst_n) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    // Register write over the configuration port; any known index restarts the image
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PIXEL_FORMAT: fmt_reg    = data[2:0];
            REG_IMAGE_WIDTH:  width_reg  = data[8:0];
            REG_IMAGE_HEIGHT: height_reg = data[8:0];
            default:          return;
        endcase
        byte_pos = 0;
        cur_row  = 0;
        cur_col  = 0;
        pix_byte = 0;
        gather   = '0;
    endtask

    // Write all three registers, with junk in the unused upper bits
    task automatic set_image(input logic [2:0] f, input logic [8:0] w, input logic [8:0] h);
        logic [31:0] data;
        data = $urandom;
        data[2:0] = f;
        write_reg(REG_PIXEL_FORMAT, data);
        data = $urandom;
        data[8:0] = w;
        write_reg(REG_IMAGE_WIDTH, data);
        data = $urandom;
        data[8:0] = h;
        write_reg(REG_IMAGE_HEIGHT, data);
        settings_run++;
    endtask

    // Hold until every byte is sent and every pixel has come, then let the pipe settle
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || s_tvalid || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        logic [2:0] f;
        logic [8:0] w;
        logic [8:0] h;
        int len;
        int split;
        int random_bytes;
        random_bytes = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: one 32 bit pixel
        pending_bytes = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
        wait_idle();

        // 1 bit, zero width and height clamp to one; padding, then a new image
        set_image(FMT_1BPP, 9'd0, 9'd0);
        pending_bytes = '{8'h80, 8'h7F, 8'hFF, 8'h00, 8'h01};
        wait_idle();

        // 24 bit, two rows; a write to an unmapped index must not restart
        set_image(FMT_24BPP, 9'd1, 9'd2);
        pending_bytes = '{8'hFF, 8'h00, 8'hFF, 8'hAA, 8'h01};
        wait_idle();
        write_reg(REG_NONE, $urandom);
        pending_bytes = '{8'h02, 8'h03, 8'hFF};
        wait_idle();

        // 4 bit with a clipped second pixel
        set_image(FMT_4BPP, 9'd3, 9'd1);
        pending_bytes = '{8'h12, 8'hF0};
        wait_idle();

        // 8 bit extremes
        set_image(FMT_8BPP, 9'd2, 9'd1);
        pending_bytes = '{8'h00, 8'hFF};
        wait_idle();

        // Unused format code acts as 32 bit
        set_image(FMT_UNUSED_HI, 9'd1, 9'd1);
        pending_bytes = '{8'h10, 8'h20, 8'h30, 8'h40};
        wait_idle();

        // Random images: mostly whole images with random content, some cut short
        for (int phase = 0; random_bytes < RANDOM_BYTES; phase++) begin
            no_gaps = (phase == 2 || phase == 3);
            f = 3'($urandom_range(7));
            case ($urandom_range(9))
                0:       w = 9'd0;
                1:       w = 9'd256;
                2:       w = 9'($urandom_range(257, 511));
                3:       w = 9'd1;
                default: w = 9'($urandom_range(2, 12));
            endcase
            case ($urandom_range(7))
                0:       h = 9'd0;
                1:       h = 9'($urandom_range(256, 511));
                default: h = 9'($urandom_range(1, 3));
            endcase
            if (phase == 0)
                f = FMT_32BPP;
            else if (phase == 1)
                f = FMT_UNUSED_LO;
            set_image(f, w, h);
            len = ((eff_dim(w, DEF_MAX_WIDTH) * bits_per_pixel(f) + 31) / 32) * 4
                  * eff_dim(h, DEF_MAX_HEIGHT) + $urandom_range(0, 4);
            if (len > MAX_PHASE_LEN)
                len = MAX_PHASE_LEN;
            // Keep the byte total near the budget
            if (len > RANDOM_BYTES - random_bytes)
                len = RANDOM_BYTES - random_bytes;
            if ($urandom_range(3) == 0)
                len = $urandom_range(1, len);
            // Now and then pause the sender mid-image until every pixel is out
            split = (phase == 1 || $urandom_range(3) == 0) ? len / 2 : len;
            for (int i = 0; i < len; i++) begin
                if (i == split && split > 0)
                    wait_idle();
                pending_bytes.push_back(8'($urandom_range(255)));
            end
            random_bytes += len;
            wait_idle();
        end
        no_gaps = 1'b0;

        $display("Run covered %0d bytes and %0d pixels over %0d register settings,",
                 bytes_sent, pixels_seen, settings_run);
        $display("all pixel formats, clamped sizes, row padding and image wrap-around.");
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("ERROR: %0d mismatches, %0d pixels never arrived",
                     mismatches, expected_pixels.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dpru_pkg.sv
rtl/dpru_front.sv
rtl/dpru_queue.sv
rtl/dpru_back.sv
rtl/dib_pixel_row_unpacker_unit.sv
rtl/dpru_checker.sv
tb/tb_dib_pixel_row_unpacker_unit.sv
